// File: rtl/mrwt_pkg.sv
// Shared widths, types and status struct of the Miller-Rabin witness test unit.
package mrwt_pkg;

	localparam int MODULUS_BITS = 63;
	localparam int CNT_W        = $clog2(MODULUS_BITS);

	typedef logic [MODULUS_BITS-1:0] operand_t;
	typedef logic [MODULUS_BITS:0]   wide_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	localparam cnt_t     LAST_STEP = cnt_t'(MODULUS_BITS - 1);
	localparam operand_t ONE       = operand_t'(1);

	// Status of an iterative arithmetic unit.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

// File: rtl/miller_rabin_witness_test_unit.sv
// Top level of the Miller-Rabin witness test unit: sequencer around a remainder unit and a shared multiplier.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  in      | to unit   | in_valid / in_stall | modulus[62:0], witness[62:0]
//  out     | from unit | out_valid/out_stall | composite
//
// Work: one transaction first reduces the witness, then runs modular multiplications
//   of 63 shift-add steps each, at most (popcount(q) + bitlen(q) - 1 + k - 1) of them,
//   all on the shared shift-add multiplier.
// A modulus below three skips both arithmetic units.
// Reset: arst_n clears the sequencer and the output valid; no clearing pass.
// Stalls: in_stall is high while a transaction is at work or waits for the output
//   register; a finished result waits there, and a new transaction can be taken meanwhile.
module miller_rabin_witness_test_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  mrwt_pkg::operand_t      modulus,
	input  mrwt_pkg::operand_t      witness,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    composite
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_REDUCE   = 8'b0000_0010,
		S_EXP      = 8'b0000_0100,
		S_MUL_ACC  = 8'b0000_1000,
		S_MUL_BASE = 8'b0001_0000,
		S_CHECK    = 8'b0010_0000,
		S_SQR      = 8'b0100_0000,
		S_DONE     = 8'b1000_0000
	} state_t;

	state_t                 state_q;
	logic                   comp_q;
	logic                   out_valid_q;
	logic                   composite_q;

	mrwt_pkg::operand_t     n_q;     // modulus
	mrwt_pkg::operand_t     a_q;     // base, repeatedly squared
	mrwt_pkg::operand_t     acc_q;   // power accumulator, then x of the squaring chain
	mrwt_pkg::operand_t     e_q;     // n-1 during stripping, then remaining exponent
	mrwt_pkg::cnt_t         k_q;     // factors of two, then squarings left

	logic                   in_fire;
	logic                   out_load;
	logic                   small_n;
	logic                   red_start;
	logic                   mm_start;
	logic                   hit_pass;
	logic                   sqr_hit;
	mrwt_pkg::operand_t     nm1;
	mrwt_pkg::operand_t     mm_x;
	mrwt_pkg::operand_t     mm_y;
	mrwt_pkg::operand_t     mm_res;
	mrwt_pkg::operand_t     red_rem;
	mrwt_pkg::unit_stat_t   mm_stat;
	mrwt_pkg::unit_stat_t   red_stat;

	assign in_stall = (state_q != S_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign small_n  = (modulus < mrwt_pkg::operand_t'(3));
	assign nm1      = n_q - mrwt_pkg::ONE;
	assign hit_pass = (acc_q == mrwt_pkg::ONE) || (acc_q == nm1);
	assign sqr_hit  = (mm_res == nm1);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// Launch the remainder unit straight from the input ports.
	assign red_start = in_fire && !small_n;

	// Issue a multiplication: accumulator step, base square, or the squaring chain.
	always_comb begin
		mm_start = 1'b0;
		unique case (state_q)
			S_EXP:   mm_start = (e_q != '0);
			S_CHECK: mm_start = !hit_pass && (k_q >= mrwt_pkg::cnt_t'(2));
			S_SQR:   mm_start = mm_stat.done && !sqr_hit && (k_q != mrwt_pkg::cnt_t'(1));
			default: mm_start = 1'b0;
		endcase
	end

	// Chain squarings restart on the fresh product before acc_q catches up.
	assign mm_x = (state_q == S_SQR) ? mm_res :
	              (((state_q == S_EXP) && !e_q[0]) ? a_q : acc_q);
	assign mm_y = (state_q == S_SQR) ? mm_res :
	              ((state_q == S_EXP) ? a_q : acc_q);

	mrwt_reduce u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (red_start),
		.dividend (witness),
		.divisor  (modulus),
		.stat     (red_stat),
		.rem      (red_rem)
	);

	mrwt_modmul u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mm_start),
		.x       (mm_x),
		.y       (mm_y),
		.m       (n_q),
		.stat    (mm_stat),
		.product (mm_res)
	);

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			comp_q      <= 1'b0;
			out_valid_q <= 1'b0;
			composite_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				composite_q <= comp_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (small_n) begin
							// Zero and one are no candidates; two is prime.
							comp_q  <= (modulus != mrwt_pkg::operand_t'(2));
							state_q <= S_DONE;
						end else begin
							state_q <= S_REDUCE;
						end
					end
				end
				S_REDUCE: begin
					if (red_stat.done) begin
						state_q <= S_EXP;
					end
				end
				S_EXP: begin
					if (e_q == '0) begin
						state_q <= S_CHECK;
					end else if (e_q[0]) begin
						state_q <= S_MUL_ACC;
					end else begin
						state_q <= S_MUL_BASE;
					end
				end
				S_MUL_ACC, S_MUL_BASE: begin
					if (mm_stat.done) begin
						state_q <= S_EXP;
					end
				end
				S_CHECK: begin
					if (hit_pass) begin
						comp_q  <= 1'b0;
						state_q <= S_DONE;
					end else if (k_q < mrwt_pkg::cnt_t'(2)) begin
						comp_q  <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SQR;
					end
				end
				S_SQR: begin
					if (mm_stat.done) begin
						if (sqr_hit) begin
							comp_q  <= 1'b0;
							state_q <= S_DONE;
						end else if (k_q == mrwt_pkg::cnt_t'(1)) begin
							comp_q  <= 1'b1;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					// Hold until the output register is free.
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					n_q <= modulus;
					e_q <= modulus - mrwt_pkg::ONE;
					k_q <= '0;
				end
			end
			S_REDUCE: begin
				// Strip factors of two from n-1 while the witness is reduced;
				// stripping always ends before the remainder unit does.
				if (!e_q[0]) begin
					e_q <= e_q >> 1;
					k_q <= k_q + mrwt_pkg::cnt_t'(1);
				end
				if (red_stat.done) begin
					a_q   <= red_rem;
					acc_q <= mrwt_pkg::ONE;
				end
			end
			S_MUL_ACC: begin
				if (mm_stat.done) begin
					acc_q <= mm_res;
					e_q   <= {e_q[mrwt_pkg::MODULUS_BITS-1:1], 1'b0};
				end
			end
			S_MUL_BASE: begin
				if (mm_stat.done) begin
					a_q <= mm_res;
					e_q <= e_q >> 1;
				end
			end
			S_CHECK: begin
				if (mm_start) begin
					k_q <= k_q - mrwt_pkg::cnt_t'(1);
				end
			end
			S_SQR: begin
				if (mm_stat.done) begin
					acc_q <= mm_res;
				end
				if (mm_start) begin
					k_q <= k_q - mrwt_pkg::cnt_t'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign composite = composite_q;

	a_base_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXP |-> (a_q < n_q) && (acc_q < n_q))
		else $error("exponentiation operand not reduced");
	a_units_apart: assert property (@(posedge clk) disable iff (!arst_n)
		red_stat.busy |-> !mm_stat.busy)
		else $error("remainder unit and multiplier busy together");
	a_wait_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL_ACC || state_q == S_MUL_BASE || state_q == S_SQR)
		|-> mm_stat.busy || mm_stat.done)
		else $error("sequencer waits on an idle multiplier");
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && (state_q == S_IDLE))
		else $error("result not presented after completion");

endmodule

// File: rtl/mrwt_reduce.sv
// Restoring remainder unit: dividend mod divisor, one dividend bit per cycle.
module mrwt_reduce (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  mrwt_pkg::operand_t      dividend,
	input  mrwt_pkg::operand_t      divisor,
	output mrwt_pkg::unit_stat_t    stat,
	output mrwt_pkg::operand_t      rem
);

	logic                busy_q;
	logic                done_q;
	mrwt_pkg::cnt_t      cnt_q;
	mrwt_pkg::operand_t  num_q;
	mrwt_pkg::operand_t  div_q;
	mrwt_pkg::operand_t  rem_q;
	mrwt_pkg::wide_t     trial;
	mrwt_pkg::wide_t     rem_next;

	// Shift in the next dividend bit, subtract the divisor once if it fits.
	always_comb begin
		trial = {rem_q, num_q[mrwt_pkg::MODULUS_BITS-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_next = trial - {1'b0, div_q};
		end else begin
			rem_next = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + mrwt_pkg::cnt_t'(1);
				if (cnt_q == mrwt_pkg::LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= rem_next[mrwt_pkg::MODULUS_BITS-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = rem_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("reduce started while busy");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < div_q) else $error("partial remainder not below divisor");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("reduce done held over two cycles");

endmodule

// File: rtl/mrwt_modmul.sv
// Shift-add modular multiplier: x * y mod m, one multiplier bit per cycle.
module mrwt_modmul (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  mrwt_pkg::operand_t      x,
	input  mrwt_pkg::operand_t      y,
	input  mrwt_pkg::operand_t      m,
	output mrwt_pkg::unit_stat_t    stat,
	output mrwt_pkg::operand_t      product
);

	logic                busy_q;
	logic                done_q;
	mrwt_pkg::cnt_t      cnt_q;
	mrwt_pkg::operand_t  acc_q;
	mrwt_pkg::operand_t  addend_q;
	mrwt_pkg::operand_t  mult_q;
	mrwt_pkg::operand_t  mod_q;
	mrwt_pkg::operand_t  acc_next;
	mrwt_pkg::operand_t  addend_next;

	// (a + b) mod mod_q for a, b below mod_q.
	function automatic mrwt_pkg::operand_t add_mod(mrwt_pkg::operand_t a,
	                                               mrwt_pkg::operand_t b,
	                                               mrwt_pkg::operand_t md);
		mrwt_pkg::wide_t s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, md}) begin
			s = s - {1'b0, md};
		end
		return s[mrwt_pkg::MODULUS_BITS-1:0];
	endfunction

	// Accumulate and double in parallel: two independent add-and-compare paths.
	always_comb begin
		acc_next    = mult_q[0] ? add_mod(acc_q, addend_q, mod_q) : acc_q;
		addend_next = add_mod(addend_q, addend_q, mod_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + mrwt_pkg::cnt_t'(1);
				if (cnt_q == mrwt_pkg::LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			addend_q <= x;
			mult_q   <= y;
			mod_q    <= m;
		end else if (busy_q) begin
			acc_q    <= acc_next;
			addend_q <= addend_next;
			mult_q   <= mult_q >> 1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = acc_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("multiplier started while busy");
	a_acc_below: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (acc_q < mod_q) && (addend_q < mod_q))
		else $error("multiplier operand left the residue range");
	a_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("multiplier done while still busy");

endmodule
